// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An expression that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant violated");

// A condition whose consequence must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication violated");

// A condition whose consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`endif

// ===== hw/rtl/bpdc_pkg.sv =====
// Package with the types and constants of the button press duration classifier.
`timescale 1ns / 1ps

package bpdc_pkg;

   // Field widths.
   localparam int TICK_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic              PULLED_HIGH_RESET = 1'b0;
   localparam logic [TICK_W-1:0] SHORT_TIME_RESET  = 16'd3000;
   localparam logic [TICK_W-1:0] LONG_TIME_RESET   = 16'd10000;

   // Saturation value of the held tick counter.
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Register indexes, taken from csr_paddr[3:2].
   typedef enum logic [1:0] {
      REG_PULLED_HIGH = 2'd0,
      REG_SHORT_TIME  = 2'd1,
      REG_LONG_TIME   = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   // Result event codes.
   typedef enum logic [2:0] {
      EV_NONE          = 3'd0,
      EV_SHORT_REACHED = 3'd1,
      EV_LONG_REACHED  = 3'd2,
      EV_REL_PLAIN     = 3'd3,
      EV_REL_SHORT     = 3'd4,
      EV_REL_LONG      = 3'd5
   } event_type;

   // Which hold thresholds have already been announced during a press.
   typedef enum logic [1:0] {
      STAGE_NONE  = 2'd0,
      STAGE_SHORT = 2'd1,
      STAGE_LONG  = 2'd2
   } stage_type;

   // Configuration registers as seen by the classifier core.
   typedef struct packed {
      logic              pulled_high;
      logic [TICK_W-1:0] short_time;
      logic [TICK_W-1:0] long_time;
   } cfg_type;

   // Status of the classifier core, for checking at the top level.
   typedef struct packed {
      logic      pressed;
      logic      held;
      stage_type stage;
   } status_type;

endpackage

// ===== hw/rtl/bpdc_core.sv =====
// Press state and event classification for one tick item.
`timescale 1ns / 1ps

module bpdc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_accept,
   input  logic                 pin_level,
   input  bpdc_pkg::cfg_type    cfg,
   output bpdc_pkg::event_type  event_res,
   output bpdc_pkg::status_type status
);

   logic                        held_ff;
   logic                        held_in;
   logic [bpdc_pkg::TICK_W-1:0] ticks_ff;
   logic [bpdc_pkg::TICK_W-1:0] ticks_in;
   bpdc_pkg::stage_type         stage_ff;
   bpdc_pkg::stage_type         stage_in;

   logic                        pressed;
   logic [bpdc_pkg::TICK_W-1:0] count_next;
   logic                        over_long;
   logic                        over_short;

   // Pressed level follows the pull setting; the count saturates at its maximum.
   assign pressed    = (pin_level != cfg.pulled_high);
   assign count_next = (ticks_ff == bpdc_pkg::TICK_MAX) ? ticks_ff
                                                        : ticks_ff + 1'b1;
   assign over_long  = (count_next > cfg.long_time);
   assign over_short = (count_next > cfg.short_time);

   // Event for the current tick item.
   always_comb begin
      event_res = bpdc_pkg::EV_NONE;
      if (pressed && held_ff) begin
         if (over_long && stage_ff == bpdc_pkg::STAGE_SHORT) begin
            event_res = bpdc_pkg::EV_LONG_REACHED;
         end else if (over_short && stage_ff == bpdc_pkg::STAGE_NONE) begin
            event_res = bpdc_pkg::EV_SHORT_REACHED;
         end
      end else if (!pressed && held_ff) begin
         if (over_long) begin
            event_res = bpdc_pkg::EV_REL_LONG;
         end else if (over_short) begin
            event_res = bpdc_pkg::EV_REL_SHORT;
         end else begin
            event_res = bpdc_pkg::EV_REL_PLAIN;
         end
      end
   end

   // Next press state.
   always_comb begin
      held_in  = held_ff;
      ticks_in = ticks_ff;
      stage_in = stage_ff;
      if (pressed && !held_ff) begin
         // A new press starts: only set up the state.
         held_in  = 1'b1;
         ticks_in = '0;
         stage_in = bpdc_pkg::STAGE_NONE;
      end else if (pressed) begin
         ticks_in = count_next;
         if (event_res == bpdc_pkg::EV_LONG_REACHED) begin
            stage_in = bpdc_pkg::STAGE_LONG;
         end else if (event_res == bpdc_pkg::EV_SHORT_REACHED) begin
            stage_in = bpdc_pkg::STAGE_SHORT;
         end
      end else if (held_ff) begin
         // Release: clear everything.
         held_in  = 1'b0;
         ticks_in = '0;
         stage_in = bpdc_pkg::STAGE_NONE;
      end
   end

   // State registers, updated once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         ticks_ff <= '0;
         stage_ff <= bpdc_pkg::STAGE_NONE;
      end else if (item_accept) begin
         held_ff  <= held_in;
         ticks_ff <= ticks_in;
         stage_ff <= stage_in;
      end
   end

   assign status.pressed = pressed;
   assign status.held    = held_ff;
   assign status.stage   = stage_ff;

endmodule

// ===== hw/rtl/button_press_duration_classifier.sv =====
// Top level of the button press duration classifier: channels, registers, result stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// Each input item on the req_ stream is one millisecond tick carrying the
// sampled pin level in req_tdata[0]. Every item gives exactly one result item
// on the rsp_ stream: an event code in rsp_tdata[2:0] (none, short reached,
// long reached, released plain, released short, released long) and the pin
// level echoed in rsp_tdata[3].
// The classification is combinational in the core logic; the result lands
// in the output register, so rsp_tvalid rises in the cycle after the accept.
// Throughput is one item per cycle: req_tready is high whenever the output
// register is empty or being emptied in the same cycle.
// When the receiver stalls, the result holds in the output register and
// req_tready drops until it is taken; no item is lost or repeated.
// Reset clears the press state and the output register and loads the
// registers with their defaults (pull-down, 3000 and 10000 ticks).
// Registers are written over the csr_ port at byte addresses 0, 4 and 8; the user
// must write them only while the block is idle, which the block does not enforce.
module button_press_duration_classifier (
   input  logic        clock,
   input  logic        reset,
   // Input stream. tdata: [0] pin_level, [7:1] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Result stream. tdata: [2:0] event_res, [3] level_seen, [7:4] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [bpdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bpdc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bpdc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);

   bpdc_pkg::cfg_type     cfg_ff;
   bpdc_pkg::reg_index_type csr_index;
   logic                  csr_write;

   logic                  item_accept;
   bpdc_pkg::event_type   core_event;
   bpdc_pkg::status_type  core_status;

   logic                  rsp_valid_ff;
   bpdc_pkg::event_type   rsp_event_ff;
   logic                  rsp_level_ff;

   // Register port decode.
   assign csr_pready = 1'b1;
   assign csr_index  = bpdc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulled_high <= bpdc_pkg::PULLED_HIGH_RESET;
         cfg_ff.short_time  <= bpdc_pkg::SHORT_TIME_RESET;
         cfg_ff.long_time   <= bpdc_pkg::LONG_TIME_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            bpdc_pkg::REG_PULLED_HIGH: cfg_ff.pulled_high <= csr_pwdata[0];
            bpdc_pkg::REG_SHORT_TIME:
               cfg_ff.short_time <= csr_pwdata[bpdc_pkg::TICK_W-1:0];
            bpdc_pkg::REG_LONG_TIME:
               cfg_ff.long_time  <= csr_pwdata[bpdc_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         bpdc_pkg::REG_PULLED_HIGH: csr_prdata[0] = cfg_ff.pulled_high;
         bpdc_pkg::REG_SHORT_TIME:
            csr_prdata[bpdc_pkg::TICK_W-1:0] = cfg_ff.short_time;
         bpdc_pkg::REG_LONG_TIME:
            csr_prdata[bpdc_pkg::TICK_W-1:0] = cfg_ff.long_time;
         default: csr_prdata = '0;
      endcase
   end

   // Accept an item whenever the output register is free or being drained.
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign item_accept = req_tvalid && req_tready;

   bpdc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .pin_level   (req_tdata[0]),
      .cfg         (cfg_ff),
      .event_res   (core_event),
      .status      (core_status)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept) begin
         rsp_event_ff <= core_event;
         rsp_level_ff <= req_tdata[0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_level_ff, rsp_event_ff};

   // Checks on the press state and the result stage.
   `ASSERT_SAME(a_idle_stage_clear, clock, reset, !core_status.held,
      core_status.stage == bpdc_pkg::STAGE_NONE)
   `ASSERT_NEXT(a_release_clears, clock, reset,
      item_accept && !core_status.pressed && core_status.held, !core_status.held)
   `ASSERT_NEXT(a_long_after_short, clock, reset,
      item_accept && core_event == bpdc_pkg::EV_LONG_REACHED,
      core_status.stage == bpdc_pkg::STAGE_LONG && $past(core_status.stage)
      == bpdc_pkg::STAGE_SHORT)
   `ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_valid_ff && !rsp_tready,
      !req_tready)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the button press duration classifier.
`timescale 1ns / 1ps

module tb;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 9;
   localparam int QUIET_LIMIT    = 4000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int MAX_PRINTED    = 100;

   // One expected result item: event code and the echoed pin level.
   typedef struct {
      bpdc_pkg::event_type ev;
      logic                level;
   } tick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [bpdc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [bpdc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [bpdc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the registers and of the press state.
   logic                        cfg_pulled_high = bpdc_pkg::PULLED_HIGH_RESET;
   logic [bpdc_pkg::TICK_W-1:0] cfg_short_ms = bpdc_pkg::SHORT_TIME_RESET;
   logic [bpdc_pkg::TICK_W-1:0] cfg_long_ms = bpdc_pkg::LONG_TIME_RESET;
   logic                        btn_held = 1'b0;
   logic [bpdc_pkg::TICK_W-1:0] btn_ticks = '0;
   bpdc_pkg::stage_type         btn_stage = bpdc_pkg::STAGE_NONE;

   tick_result_type expected_events[$];
   int error_count = 0;

   // Idling controls for the sender and the receiver, and the watchdog count.
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int holdoff_seq = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int quiet_cycles = 0;

   button_press_duration_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Prints one mismatch line, up to a cap, and counts every one.
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("tb: mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   // Advances the shadow press state by one tick and returns the event it gives.
   function automatic bpdc_pkg::event_type classify_tick(input logic level);
      logic                        pressed;
      logic [bpdc_pkg::TICK_W-1:0] count;
      bpdc_pkg::event_type         ev;
      pressed = (level != cfg_pulled_high);
      count = (btn_ticks == bpdc_pkg::TICK_MAX) ? bpdc_pkg::TICK_MAX : btn_ticks + 1'b1;
      ev = bpdc_pkg::EV_NONE;
      if (pressed) begin
         if (!btn_held) begin
            btn_held = 1'b1;
            btn_ticks = '0;
            btn_stage = bpdc_pkg::STAGE_NONE;
         end else begin
            btn_ticks = count;
            // The long check wins, but only once the short event has been given.
            if (btn_ticks > cfg_long_ms && btn_stage == bpdc_pkg::STAGE_SHORT) begin
               ev = bpdc_pkg::EV_LONG_REACHED;
               btn_stage = bpdc_pkg::STAGE_LONG;
            end else if (btn_ticks > cfg_short_ms && btn_stage == bpdc_pkg::STAGE_NONE) begin
               ev = bpdc_pkg::EV_SHORT_REACHED;
               btn_stage = bpdc_pkg::STAGE_SHORT;
            end
         end
      end else if (btn_held) begin
         if (count > cfg_long_ms) begin
            ev = bpdc_pkg::EV_REL_LONG;
         end else if (count > cfg_short_ms) begin
            ev = bpdc_pkg::EV_REL_SHORT;
         end else begin
            ev = bpdc_pkg::EV_REL_PLAIN;
         end
         btn_held = 1'b0;
         btn_ticks = '0;
         btn_stage = bpdc_pkg::STAGE_NONE;
      end
      return ev;
   endfunction

   // Offers one tick after a random gap and records its expected result once accepted.
   task automatic send_tick(input logic level);
      tick_result_type want;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, level};
      do @(posedge clock); while (!req_tready);
      want.ev = classify_tick(level);
      want.level = level;
      expected_events.push_back(want);
   endtask

   // One register access: a setup phase, an access phase, then an idle phase.
   task automatic csr_access(input logic is_write, input bpdc_pkg::reg_index_type idx,
                             input logic [bpdc_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [bpdc_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reads a register and compares it with the value it should hold.
   task automatic csr_check(input bpdc_pkg::reg_index_type idx,
                            input logic [bpdc_pkg::CSR_DATA_W-1:0] want);
      logic [bpdc_pkg::CSR_DATA_W-1:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got !== want) begin
         report_mismatch($sformatf("register %s reads %h, want %h", idx.name(), got, want));
      end
   endtask

   // Writes a register, updates the shadow copy and reads it back.
   task automatic csr_write(input bpdc_pkg::reg_index_type idx,
                            input logic [bpdc_pkg::CSR_DATA_W-1:0] value);
      logic [bpdc_pkg::CSR_DATA_W-1:0] unused;
      csr_access(1'b1, idx, value, unused);
      case (idx)
         bpdc_pkg::REG_PULLED_HIGH: begin
            cfg_pulled_high = value[0];
            csr_check(idx, {31'b0, cfg_pulled_high});
         end
         bpdc_pkg::REG_SHORT_TIME: begin
            cfg_short_ms = value[bpdc_pkg::TICK_W-1:0];
            csr_check(idx, {16'b0, cfg_short_ms});
         end
         bpdc_pkg::REG_LONG_TIME: begin
            cfg_long_ms = value[bpdc_pkg::TICK_W-1:0];
            csr_check(idx, {16'b0, cfg_long_ms});
         end
         default: begin
         end
      endcase
   endtask

   // Stops offering ticks and waits until every expected result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic apply_config(input logic pulled, input int short_ms, input int long_ms);
      drain();
      csr_write(bpdc_pkg::REG_PULLED_HIGH, {31'b0, pulled});
      csr_write(bpdc_pkg::REG_SHORT_TIME, short_ms);
      csr_write(bpdc_pkg::REG_LONG_TIME, long_ms);
   endtask

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
   endtask

   // Sends a sequence of pin levels given as a bit string, lowest bit first.
   task automatic send_levels(input int count, input logic [31:0] levels);
      int i;
      for (i = 0; i < count; i++) begin
         send_tick(levels[i]);
      end
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (holdoff_seq != holdoff_seen) begin
         holdoff_seen = holdoff_seq;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Compares each result item with the oldest expected one.
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("result %h with no tick pending", rsp_tdata));
         end else begin
            want = expected_events.pop_front();
            if (rsp_tdata[2:0] !== want.ev) begin
               report_mismatch($sformatf("event_res %0d, want %s", rsp_tdata[2:0],
                                         want.ev.name()));
            end
            if (rsp_tdata[3] !== want.level) begin
               report_mismatch($sformatf("level_seen %b, want %b", rsp_tdata[3], want.level));
            end
            if (rsp_tdata[7:4] !== 4'b0) begin
               report_mismatch($sformatf("padding bits %b, want zero", rsp_tdata[7:4]));
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Registers must come out of reset with their default values.
   task automatic test_register_defaults();
      csr_check(bpdc_pkg::REG_PULLED_HIGH, {31'b0, bpdc_pkg::PULLED_HIGH_RESET});
      csr_check(bpdc_pkg::REG_SHORT_TIME, {16'b0, bpdc_pkg::SHORT_TIME_RESET});
      csr_check(bpdc_pkg::REG_LONG_TIME, {16'b0, bpdc_pkg::LONG_TIME_RESET});
   endtask

   // A press well below the default thresholds, with a release before any press.
   task automatic test_default_thresholds();
      int i;
      set_idling(0, 0);
      send_tick(1'b0);
      for (i = 0; i < 25; i++) begin
         send_tick(1'b1);
      end
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // Short directed sequences around zero thresholds, both pull settings and
   // a long threshold set below the short one.
   task automatic test_directed_cases();
      apply_config(1'b0, 0, 0);
      send_levels(8, 32'b0101_1110);
      apply_config(1'b1, 2, 1);
      send_levels(7, 32'b110_0000);
      apply_config(1'b1, 1, 3);
      send_levels(5, 32'b1_0100);
   endtask

   // A write to the unused index must leave every register as it was.
   task automatic test_register_map();
      drain();
      csr_write(bpdc_pkg::REG_UNUSED, 32'hFFFF_FFFF);
      csr_check(bpdc_pkg::REG_PULLED_HIGH, {31'b0, cfg_pulled_high});
      csr_check(bpdc_pkg::REG_SHORT_TIME, {16'b0, cfg_short_ms});
      csr_check(bpdc_pkg::REG_LONG_TIME, {16'b0, cfg_long_ms});
   endtask

   // Thresholds just below the top of their range are not exceeded by a plain press.
   task automatic test_top_thresholds();
      int i;
      apply_config(1'b0, 65534, 65534);
      set_idling(0, 0);
      send_tick(1'b0);
      for (i = 0; i < 30; i++) begin
         send_tick(1'b1);
      end
      send_tick(1'b0);
   endtask

   // The receiver holds off for a long stretch while ticks keep coming.
   task automatic test_backpressure();
      int i;
      apply_config(1'b0, 4, 9);
      set_idling(0, 0);
      holdoff_seq++;
      for (i = 0; i < 60; i++) begin
         send_tick((i % 15) != 14);
      end
      send_tick(1'b0);
   endtask

   function automatic int random_threshold();
      case ($urandom_range(7))
         0: return 0;
         1: return 65534;
         2: return $urandom_range(65534);
         default: return $urandom_range(15);
      endcase
   endfunction

   // Mostly whole presses of random length, with some random noise ticks.
   task automatic test_random_presses();
      int phase;
      int sent;
      int hold;
      int rel;
      int i;
      logic pressed_level;
      for (phase = 0; phase < 8; phase++) begin
         apply_config(1'($urandom_range(1)), random_threshold(), random_threshold());
         case (phase % 4)
            0: set_idling(0, 0);
            1: set_idling(69, 0);
            2: set_idling(0, 69);
            default: set_idling(31, 31);
         endcase
         sent = 0;
         while (sent < 220) begin
            if ($urandom_range(99) < 20) begin
               send_tick(1'($urandom_range(1)));
               sent++;
            end else begin
               pressed_level = !cfg_pulled_high;
               hold = $urandom_range(24, 1);
               rel = $urandom_range(3, 1);
               for (i = 0; i < hold; i++) begin
                  send_tick(pressed_level);
               end
               for (i = 0; i < rel; i++) begin
                  send_tick(!pressed_level);
               end
               sent += hold + rel;
            end
         end
      end
   endtask

   // Test sequence and final verdict.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_default_thresholds();
      test_directed_cases();
      test_register_map();
      test_top_thresholds();
      test_backpressure();
      test_random_presses();
      drain();
      repeat (4) @(posedge clock);
      if (expected_events.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_events.size()));
      end
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bpdc_pkg.sv
hw/rtl/bpdc_core.sv
hw/rtl/button_press_duration_classifier.sv
verif/tb.sv
